FILE: src/drt_pkg.sv
// shared types and constants for the discovery result table
// no dependencies
package drt_pkg;

    localparam int DRT_DEPTH_DEFAULT = 16;
    localparam int KEY_W             = 64;
    localparam int MAGIC_W           = 32;
    localparam int HALF_W            = 16;
    localparam int COUNT_OUT_W       = 5;

    // command codes
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_FIND = 1'b1;

    // one stored record, laid out as a single memory word
    typedef struct packed {
        logic [MAGIC_W-1:0] magic;
        logic [HALF_W-1:0]  version;
        logic [HALF_W-1:0]  vendor;
        logic [HALF_W-1:0]  device;
        logic [HALF_W-1:0]  endpoints;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

endpackage

FILE: src/drt_ram.sv
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module drt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data holds while not reading
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/discovery_result_table.sv
// discovery result table: keyed store of discovery records, put and find
// depends on drt_pkg and drt_ram
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  in      | input     | in_valid/in_stall  | cmd, key_stream_id, in_magic .. in_endpoints
//  out     | output    | out_valid/out_stall| ok, out_magic .. out_endpoints, entry_count
//
// a miss scans every stored key from acceptance to its result word (on an empty table no
// key is read): a linear scan of the key ram at one read per cycle, the registered read
// for the last compare, then a decision step that writes back a put; a hit at slot i
// ends the scan there. the block returns to idle before it takes another word.
// reset clears the entry count and the control and output registers; ram contents are undefined until written.
// a new word is taken while the previous result still waits; the decision cycle
// holds until the output register is free.
module discovery_result_table
    import drt_pkg::*;
#(
    parameter int TABLE_DEPTH = DRT_DEPTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   cmd,
    input  logic [KEY_W-1:0]       key_stream_id,
    input  logic [MAGIC_W-1:0]     in_magic,
    input  logic [HALF_W-1:0]      in_version,
    input  logic [HALF_W-1:0]      in_vendor,
    input  logic [HALF_W-1:0]      in_device,
    input  logic [HALF_W-1:0]      in_endpoints,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   ok,
    output logic [MAGIC_W-1:0]     out_magic,
    output logic [HALF_W-1:0]      out_version,
    output logic [HALF_W-1:0]      out_vendor,
    output logic [HALF_W-1:0]      out_device,
    output logic [HALF_W-1:0]      out_endpoints,
    output logic [COUNT_OUT_W-1:0] entry_count
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t           state_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    issue_reg;
    logic [AW-1:0]    slot_reg;
    logic             pend_reg;
    logic             cmd_reg;
    logic [KEY_W-1:0] key_reg;
    rec_t             rec_in_reg;
    logic             out_valid_reg;
    logic             ok_reg;
    rec_t             rec_out_reg;
    logic [CW-1:0]    count_out_reg;

    logic [KEY_W-1:0] key_rd;
    rec_t             rec_rd;
    logic             in_fire;
    logic             more;
    logic             hit;
    logic             room;
    logic             decide;
    logic             out_free;
    logic             fire;
    logic             rd_en;
    logic             key_we;
    logic             rec_we;
    logic [AW-1:0]    rec_wr_addr;
    logic             ok_next;
    rec_t             rec_out_next;
    logic [CW-1:0]    count_next;
    logic [CW+COUNT_OUT_W-1:0] count_ext;

    // key and record stores, read at the same address
    drt_ram #(
        .WIDTH(KEY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_key_ram (
        .clk    (clk),
        .wr_en  (key_we),
        .wr_addr(count_reg[AW-1:0]),
        .wr_data(key_reg),
        .rd_en  (rd_en),
        .rd_addr(issue_reg[AW-1:0]),
        .rd_data(key_rd)
    );

    drt_ram #(
        .WIDTH(REC_W),
        .DEPTH(TABLE_DEPTH)
    ) u_rec_ram (
        .clk    (clk),
        .wr_en  (rec_we),
        .wr_addr(rec_wr_addr),
        .wr_data(rec_in_reg),
        .rd_en  (rd_en),
        .rd_addr(issue_reg[AW-1:0]),
        .rd_data(rec_rd)
    );

    // scan control
    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign more     = (issue_reg < count_reg);
    assign hit      = pend_reg && (key_rd == key_reg);
    assign room     = (count_reg < CW'(TABLE_DEPTH));
    assign decide   = (state_reg == ST_SCAN) && (hit || (!pend_reg && !more));
    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = decide && out_free;
    assign rd_en    = (state_reg == ST_SCAN) && !decide && more;

    // write back in the decision cycle
    assign key_we      = fire && (cmd_reg == CMD_PUT) && !hit && room;
    assign rec_we      = fire && (cmd_reg == CMD_PUT) && (hit || room);
    assign rec_wr_addr = hit ? slot_reg : count_reg[AW-1:0];

    // result word
    always_comb
    begin
        ok_next      = 1'b0;
        rec_out_next = '0;
        count_next   = count_reg;
        if (cmd_reg == CMD_PUT)
        begin
            ok_next = hit || room;
            if (!hit && room)
            begin
                count_next = count_reg + CW'(1);
            end
        end
        else if (hit)
        begin
            ok_next      = 1'b1;
            rec_out_next = rec_rd;
        end
    end

    // state, datapath and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            slot_reg      <= '0;
            pend_reg      <= 1'b0;
            cmd_reg       <= CMD_PUT;
            key_reg       <= '0;
            rec_in_reg    <= '0;
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            rec_out_reg   <= '0;
            count_out_reg <= '0;
        end
        else
        begin
            // output word valid: set by the decision, cleared when taken
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        cmd_reg              <= cmd;
                        key_reg              <= key_stream_id;
                        rec_in_reg.magic     <= in_magic;
                        rec_in_reg.version   <= in_version;
                        rec_in_reg.vendor    <= in_vendor;
                        rec_in_reg.device    <= in_device;
                        rec_in_reg.endpoints <= in_endpoints;
                        issue_reg            <= '0;
                        pend_reg             <= 1'b0;
                        state_reg            <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (fire)
                    begin
                        count_reg     <= count_next;
                        ok_reg        <= ok_next;
                        rec_out_reg   <= rec_out_next;
                        count_out_reg <= count_next;
                        pend_reg      <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                    else if (rd_en)
                    begin
                        slot_reg  <= issue_reg[AW-1:0];
                        issue_reg <= issue_reg + CW'(1);
                        pend_reg  <= 1'b1;
                    end
                    else if (!decide)
                    begin
                        pend_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // output ports
    assign count_ext     = {{COUNT_OUT_W{1'b0}}, count_out_reg};
    assign out_valid     = out_valid_reg;
    assign ok            = ok_reg;
    assign out_magic     = rec_out_reg.magic;
    assign out_version   = rec_out_reg.version;
    assign out_vendor    = rec_out_reg.vendor;
    assign out_device    = rec_out_reg.device;
    assign out_endpoints = rec_out_reg.endpoints;
    assign entry_count   = count_ext[COUNT_OUT_W-1:0];

endmodule
